FILE: rtl/bhm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bhm_pkg;

    localparam int KEY_W    = 31;
    localparam int OUT_VAL_W = 32;
    localparam int COUNT_W  = 6;

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_REMOVE = 2'd1;
    localparam logic [1:0] REQ_LOOKUP = 2'd2;

    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_REPLACED  = 3'd1;
    localparam logic [2:0] ST_DONE      = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;

    typedef struct packed {
        logic [1:0]           req_type;
        logic [KEY_W-1:0]     key;
        logic [OUT_VAL_W-1:0] value_in;
    } req_t;

    typedef struct packed {
        logic                 found;
        logic [OUT_VAL_W-1:0] value_out;
        logic [2:0]           status;
        logic [COUNT_W-1:0]   element_count;
        logic                 map_empty;
    } rsp_t;

endpackage

`default_nettype wire

FILE: rtl/bucketed_hash_map_top.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   valid       stall       payload
// request   req_valid   req_stall   req (req_type, key, value_in)
// result    rsp_valid   rsp_stall   rsp (found, value_out, status, element_count, map_empty)
//
// Each request passes a multiply by the reciprocal of BUCKETS, a subtract
// for the bucket index, one bucket-row read from the RAM, and a match and
// update step that writes the row back on an insert, then returns to idle;
// no new request is taken before then. Reset clears the way valid bits and
// the element count at once; RAM rows are not cleared. A new request is taken
// while a result still waits; a stalled result holds the block in its update cycle.

module bucketed_hash_map_top #(
    parameter int BUCKETS    = 10,
    parameter int WAYS       = 4,
    parameter int VALUE_BITS = 32
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire bhm_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output bhm_pkg::rsp_t      rsp
);

    import bhm_pkg::*;

    localparam int SLOTS  = BUCKETS * WAYS;
    localparam int BKT_W  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int ENT_W  = KEY_W + VALUE_BITS;
    localparam int ROW_W  = WAYS * ENT_W;

    // floor(key / BUCKETS) = (key * MAGIC) >> RECIP_SH, exact for every key
    localparam int LOG_B    = $clog2(BUCKETS);
    localparam int RECIP_SH = KEY_W + LOG_B;
    localparam int MAGIC_W  = KEY_W + 1;
    localparam int PROD_W   = KEY_W + MAGIC_W;
    localparam logic [63:0] MAGIC_FULL =
        ((64'd1 << RECIP_SH) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);
    localparam logic [MAGIC_W-1:0] MAGIC     = MAGIC_FULL[MAGIC_W-1:0];
    localparam logic [KEY_W-1:0]   BUCKETS_K = KEY_W'(BUCKETS);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_SUB  = 3'd2;
    localparam logic [2:0] S_READ = 3'd3;
    localparam logic [2:0] S_EVAL = 3'd4;

    logic [2:0]            state_reg, state_next;
    logic [KEY_W-1:0]      quot_reg, quot_next;
    logic [BKT_W-1:0]      rem_reg, rem_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [WAYS-1:0]       valid_reg [BUCKETS];
    logic                  rsp_valid_reg, rsp_valid_next;
    rsp_t                  rsp_reg;
    logic [1:0]            op_reg;
    logic [KEY_W-1:0]      key_reg;
    logic [VALUE_BITS-1:0] val_reg;

    logic [PROD_W-1:0]     recip_prod;
    logic [KEY_W-1:0]      key_left;

    logic                  ram_wr;
    logic                  ram_rd;
    logic [ROW_W-1:0]      row_rd;
    logic [ROW_W-1:0]      row_new;
    logic [WAYS-1:0]       valid_row;
    logic [WAYS-1:0]       valid_new;
    logic                  commit;
    rsp_t                  rsp_new;

    logic                  req_beat;
    logic                  hit_any, free_any;
    logic [WAY_W-1:0]      hit_idx, free_idx;
    logic [VALUE_BITS-1:0] hit_val;

    assign req_beat  = req_valid && !req_stall;
    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign valid_row = valid_reg[rem_reg];
    assign ram_rd    = (state_reg == S_READ);
    assign commit    = (state_reg == S_EVAL) && (!rsp_valid_reg || !rsp_stall);

    bhm_ram #(
        .WIDTH (ROW_W),
        .DEPTH (BUCKETS),
        .AW    (BKT_W)
    ) u_row_ram (
        .clk     (clk),
        .wr_en   (ram_wr),
        .wr_addr (rem_reg),
        .wr_data (row_new),
        .rd_en   (ram_rd),
        .rd_addr (rem_reg),
        .rd_data (row_rd)
    );

    // key mod BUCKETS: quotient by reciprocal multiply, then key - quotient * BUCKETS
    assign recip_prod = PROD_W'(key_reg) * PROD_W'(MAGIC);
    assign quot_next  = KEY_W'(recip_prod >> RECIP_SH);
    assign key_left   = key_reg - quot_reg * BUCKETS_K;
    assign rem_next   = key_left[BKT_W-1:0];

    // match the bucket row
    always_comb
    begin
        hit_any  = 1'b0;
        free_any = 1'b0;
        hit_idx  = '0;
        free_idx = '0;
        hit_val  = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            if (valid_row[w] && !hit_any
                && row_rd[w*ENT_W+VALUE_BITS +: KEY_W] == key_reg)
            begin
                hit_any = 1'b1;
                hit_idx = WAY_W'(w);
                hit_val = row_rd[w*ENT_W +: VALUE_BITS];
            end
            if (!valid_row[w] && !free_any)
            begin
                free_any = 1'b1;
                free_idx = WAY_W'(w);
            end
        end
    end

    always_comb
    begin
        logic [2:0]           status;
        logic                 found;
        logic [OUT_VAL_W-1:0] vout;
        status     = ST_NOT_FOUND;
        found      = hit_any;
        vout       = '0;
        row_new    = row_rd;
        valid_new  = valid_row;
        count_next = count_reg;
        ram_wr     = 1'b0;
        case (op_reg)
            REQ_INSERT:
            begin
                if (hit_any)
                begin
                    for (int w = 0; w < WAYS; w++)
                    begin
                        if (hit_idx == WAY_W'(w))
                        begin
                            row_new[w*ENT_W +: VALUE_BITS] = val_reg;
                        end
                    end
                    status = ST_REPLACED;
                    ram_wr = commit;
                end
                else if (free_any)
                begin
                    for (int w = 0; w < WAYS; w++)
                    begin
                        if (free_idx == WAY_W'(w))
                        begin
                            row_new[w*ENT_W +: ENT_W] = {key_reg, val_reg};
                            valid_new[w] = 1'b1;
                        end
                    end
                    count_next = count_reg + 1'b1;
                    status     = ST_INSERTED;
                    ram_wr     = commit;
                end
                else
                begin
                    status = ST_FULL;
                end
            end
            REQ_REMOVE:
            begin
                if (hit_any)
                begin
                    for (int w = 0; w < WAYS; w++)
                    begin
                        if (hit_idx == WAY_W'(w))
                        begin
                            valid_new[w] = 1'b0;
                        end
                    end
                    if (count_reg != '0)
                    begin
                        count_next = count_reg - 1'b1;
                    end
                    status = ST_DONE;
                end
            end
            REQ_LOOKUP:
            begin
                if (hit_any)
                begin
                    vout   = OUT_VAL_W'(hit_val);
                    status = ST_DONE;
                end
            end
            default:
            begin
                found = 1'b0;
            end
        endcase
        rsp_new.found         = found;
        rsp_new.value_out     = vout;
        rsp_new.status        = status;
        rsp_new.element_count = COUNT_W'(count_next);
        rsp_new.map_empty     = (count_next == '0);
    end

    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg;
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (req_beat)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                state_next = S_SUB;
            end
            S_SUB:
            begin
                state_next = S_READ;
            end
            S_READ:
            begin
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (commit)
                begin
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
            for (int b = 0; b < BUCKETS; b++)
            begin
                valid_reg[b] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            if (commit)
            begin
                count_reg          <= count_next;
                valid_reg[rem_reg] <= valid_new;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_beat)
        begin
            op_reg  <= req.req_type;
            key_reg <= req.key;
            val_reg <= VALUE_BITS'(req.value_in);
        end
        if (state_reg == S_MUL)
        begin
            quot_reg <= quot_next;
        end
        if (state_reg == S_SUB)
        begin
            rem_reg <= rem_next;
        end
        if (commit)
        begin
            rsp_reg <= rsp_new;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(SLOTS))
        else $error("element count above table size");

    a_wr_in_eval: assert property (@(posedge clk) disable iff (!rst_n)
        ram_wr |-> (state_reg == S_EVAL) && !(rsp_valid_reg && rsp_stall))
        else $error("row write outside the update cycle");

    a_beat_starts_mul: assert property (@(posedge clk) disable iff (!rst_n)
        req_beat |=> (state_reg == S_MUL))
        else $error("request beat did not start the bucket computation");

    a_rsp_from_eval: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg) == S_EVAL)
        else $error("result raised outside the update cycle");

endmodule

`default_nettype wire

FILE: rtl/bhm_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module bhm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: bench/bucketed_hash_map_top_tb.sv
`timescale 1ns / 1ps

module bucketed_hash_map_top_tb;
    import bhm_pkg::*;

    localparam int NBUCKETS = 10;
    localparam int NWAYS = 4;
    localparam int NSLOTS = NBUCKETS * NWAYS;
    localparam int CYCLE_LIMIT = 800000;
    localparam int MAX_REPORTS = 10;
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp;

    // shadow copy of the table contents
    logic [KEY_W-1:0] slot_key [NSLOTS];
    logic [OUT_VAL_W-1:0] slot_val [NSLOTS];
    bit slot_used [NSLOTS];
    int entry_total = 0;

    rsp_t pending_answers[$];
    int mismatches = 0;
    int cycle_count = 0;
    int hold_left = 0;
    bit req_gaps_on = 1'b1;
    bit rsp_gaps_on = 1'b1;
    logic [KEY_W-1:0] wide_keys [8];
    logic [KEY_W-1:0] drill_keys [NSLOTS];

    bucketed_hash_map_top #(
        .BUCKETS(NBUCKETS),
        .WAYS(NWAYS),
        .VALUE_BITS(32)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp(rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    function automatic int pick_gap();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 65)
            return 0;
        if (roll < 93)
            return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    function automatic req_t make_req(logic [1:0] op, logic [KEY_W-1:0] k,
                                      logic [OUT_VAL_W-1:0] v);
        req_t r;
        r.req_type = op;
        r.key = k;
        r.value_in = v;
        return r;
    endfunction

    // table lookup/update for one request, returns the answer it should give
    function automatic rsp_t apply_request(req_t r);
        rsp_t a;
        int base;
        int hit;
        int free_way;
        int w;
        a = '0;
        base = int'(r.key % NBUCKETS) * NWAYS;
        hit = -1;
        free_way = -1;
        for (w = 0; w < NWAYS; w++)
        begin
            if (slot_used[base + w])
            begin
                if (hit < 0 && slot_key[base + w] == r.key)
                    hit = w;
            end
            else if (free_way < 0)
                free_way = w;
        end
        a.found = (hit >= 0);
        a.status = ST_NOT_FOUND;
        case (r.req_type)
            REQ_INSERT:
            begin
                if (hit >= 0)
                begin
                    slot_val[base + hit] = r.value_in;
                    a.status = ST_REPLACED;
                end
                else if (free_way >= 0)
                begin
                    slot_key[base + free_way] = r.key;
                    slot_val[base + free_way] = r.value_in;
                    slot_used[base + free_way] = 1'b1;
                    entry_total++;
                    a.status = ST_INSERTED;
                end
                else
                    a.status = ST_FULL;
            end
            REQ_REMOVE:
            begin
                if (hit >= 0)
                begin
                    slot_used[base + hit] = 1'b0;
                    if (entry_total > 0)
                        entry_total--;
                    a.status = ST_DONE;
                end
            end
            REQ_LOOKUP:
            begin
                if (hit >= 0)
                begin
                    a.value_out = slot_val[base + hit];
                    a.status = ST_DONE;
                end
            end
            default:
                a.found = 1'b0;
        endcase
        a.element_count = COUNT_W'(entry_total);
        a.map_empty = (entry_total == 0);
        return a;
    endfunction

    function automatic req_t random_item(int insert_pct, int remove_pct);
        int unsigned roll;
        logic [1:0] op;
        logic [KEY_W-1:0] k;
        logic [OUT_VAL_W-1:0] v;
        roll = $urandom_range(99);
        if (roll < 4)
            op = REQ_UNUSED;
        else if (roll < 4 + insert_pct)
            op = REQ_INSERT;
        else if (roll < 4 + insert_pct + remove_pct)
            op = REQ_REMOVE;
        else
            op = REQ_LOOKUP;
        // mostly a small pool: six keys per bucket against four ways
        roll = $urandom_range(99);
        if (roll < 80)
            k = KEY_W'($urandom_range(9) + 10 * $urandom_range(5));
        else if (roll < 92)
            k = wide_keys[$urandom_range(7)];
        else
            k = KEY_W'($urandom);
        roll = $urandom_range(99);
        if (roll < 5)
            v = '0;
        else if (roll < 10)
            v = '1;
        else
            v = $urandom;
        return make_req(op, k, v);
    endfunction

    function automatic void report(string what, logic [31:0] want, logic [31:0] got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch %s: expected %0h, got %0h (t=%0t)", what, want, got, $time);
    endfunction

    function automatic void shuffle_drill_keys();
        int i;
        int j;
        logic [KEY_W-1:0] t;
        for (i = NSLOTS - 1; i > 0; i--)
        begin
            j = $urandom_range(i);
            t = drill_keys[i];
            drill_keys[i] = drill_keys[j];
            drill_keys[j] = t;
        end
    endfunction

    // one request beat; valid stays up after the beat until the next call decides
    task automatic send_item(input req_t item);
        int gap;
        gap = req_gaps_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        req_valid <= 1'b1;
        req <= item;
        do
            @(posedge clk);
        while (req_stall);
        pending_answers.push_back(apply_request(item));
    endtask

    task automatic stop_req();
        @(negedge clk);
        req_valid <= 1'b0;
    endtask

    // result side stall generator; hold_left forces a long hold-off
    initial
    begin
        int run;
        run = 0;
        rsp_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_stall <= 1'b1;
            end
            else if (run > 0)
            begin
                run--;
                rsp_stall <= 1'b1;
            end
            else
            begin
                rsp_stall <= 1'b0;
                if (rsp_gaps_on)
                    run = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin : check_beat
        rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_answers.size() == 0)
                report("unexpected result beat, status", '0, 32'(rsp.status));
            else
            begin
                want = pending_answers.pop_front();
                if (rsp.found !== want.found)
                    report("found", 32'(want.found), 32'(rsp.found));
                if (rsp.value_out !== want.value_out)
                    report("value_out", want.value_out, rsp.value_out);
                if (rsp.status !== want.status)
                    report("status", 32'(want.status), 32'(rsp.status));
                if (rsp.element_count !== want.element_count)
                    report("element_count", 32'(want.element_count),
                           32'(rsp.element_count));
                if (rsp.map_empty !== want.map_empty)
                    report("map_empty", 32'(want.map_empty), 32'(rsp.map_empty));
            end
        end
    end

    task automatic test_basic_ops();
        send_item(make_req(REQ_LOOKUP, '0, '0));
        send_item(make_req(REQ_REMOVE, '0, 32'h1234_5678));
        send_item(make_req(REQ_INSERT, '0, '0));
        send_item(make_req(REQ_INSERT, KEY_MAX, '1));
        send_item(make_req(REQ_LOOKUP, KEY_MAX, '0));
        send_item(make_req(REQ_INSERT, '0, '1));
        send_item(make_req(REQ_LOOKUP, '0, 32'h5555_5555));
        send_item(make_req(REQ_UNUSED, '0, 32'hdead_beef));
        send_item(make_req(REQ_REMOVE, KEY_MAX, '0));
        send_item(make_req(REQ_LOOKUP, KEY_MAX, '0));
        send_item(make_req(REQ_REMOVE, '0, '0));
    endtask

    task automatic test_bucket_full();
        logic [KEY_W-1:0] bucket3 [4];
        int i;
        bucket3[0] = KEY_W'(3);
        bucket3[1] = KEY_W'(13);
        bucket3[2] = KEY_MAX - KEY_W'(4);
        bucket3[3] = KEY_W'(33);
        for (i = 0; i < 4; i++)
            send_item(make_req(REQ_INSERT, bucket3[i], $urandom));
        send_item(make_req(REQ_INSERT, KEY_W'(43), 32'haaaa_aaaa));
        send_item(make_req(REQ_LOOKUP, KEY_W'(43), '0));
        send_item(make_req(REQ_INSERT, KEY_W'(13), 32'h0f0f_0f0f));
        send_item(make_req(REQ_REMOVE, KEY_W'(13), '0));
        send_item(make_req(REQ_INSERT, KEY_W'(43), 32'h8000_0001));
        send_item(make_req(REQ_LOOKUP, KEY_W'(43), '0));
        send_item(make_req(REQ_UNUSED, KEY_W'(43), '1));
        bucket3[1] = KEY_W'(43);
        for (i = 0; i < 4; i++)
            send_item(make_req(REQ_REMOVE, bucket3[i], '0));
    endtask

    // keys 0..39 fill every way of every bucket
    task automatic test_fill_and_drain();
        int i;
        for (i = 0; i < NSLOTS; i++)
            drill_keys[i] = KEY_W'(i);
        shuffle_drill_keys();
        for (i = 0; i < NSLOTS; i++)
            send_item(make_req(REQ_INSERT, drill_keys[i], $urandom));
        send_item(make_req(REQ_INSERT, KEY_W'(40 + $urandom_range(9)), $urandom));
        for (i = 0; i < 10; i++)
            send_item(make_req(REQ_LOOKUP, drill_keys[$urandom_range(NSLOTS - 1)], '0));
        shuffle_drill_keys();
        for (i = 0; i < NSLOTS; i++)
            send_item(make_req(REQ_REMOVE, drill_keys[i], '0));
    endtask

    task automatic test_random_mix(int phases, int per_phase);
        int p;
        bit filling;
        for (p = 0; p < phases; p++)
        begin
            filling = (p % 2 == 0);
            req_gaps_on = ($urandom_range(3) != 0);
            rsp_gaps_on = ($urandom_range(3) != 0);
            repeat (per_phase)
                send_item(random_item(filling ? 55 : 15, filling ? 15 : 55));
        end
        req_gaps_on = 1'b1;
        rsp_gaps_on = 1'b1;
    endtask

    task automatic test_backpressure();
        req_gaps_on = 1'b0;
        hold_left = 300;
        repeat (60)
            send_item(random_item(40, 30));
        req_gaps_on = 1'b1;
    endtask

    task automatic test_pause_drain();
        repeat (40)
            send_item(random_item(40, 30));
        stop_req();
        wait (pending_answers.size() == 0);
        repeat (40)
            send_item(random_item(40, 30));
    endtask

    initial
    begin
        int i;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        for (i = 0; i < NSLOTS; i++)
        begin
            slot_used[i] = 1'b0;
            slot_key[i] = '0;
            slot_val[i] = '0;
        end
        wide_keys[0] = KEY_MAX;
        wide_keys[1] = KEY_W'(1) << (KEY_W - 1);
        for (i = 2; i < 8; i++)
            wide_keys[i] = KEY_W'($urandom);
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        test_basic_ops();
        test_bucket_full();
        test_fill_and_drain();
        test_random_mix(8, 200);
        test_backpressure();
        test_pause_drain();

        stop_req();
        wait (pending_answers.size() == 0);
        repeat (20) @(posedge clk);
        if (mismatches == 0 && pending_answers.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
